@@ rtl/assert_macros.svh @@
// Assertion macros for the text console buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check on every clock edge outside reset.
`define TCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, during reset too.
`define TCB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define TCB_ASSERT(lbl, prop, msg)
`define TCB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/tcb_pkg.sv @@
// Types and constants for the text console buffer.
`default_nettype none

package tcb_pkg;

  localparam int ROWS_DEF = 16;
  localparam int COLS_DEF = 64;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_NUL     = 8'd0;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_NEWLINE,
    KIND_RETURN,
    KIND_PRINT
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ch;
    logic        rd_ok;
    logic [3:0]  rd_row;
    logic [6:0]  rd_col;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic hold;
  } q_ctl_t;

endpackage

`default_nettype wire

@@ rtl/tcb_front.sv @@
// Front end: accepts input beats, classifies them and queues the commands.
`default_nettype none

module tcb_front import tcb_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] char_code, [11:8] read_row, [18:12] read_col, [23:19] zero
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  // [0] action
  input  wire logic                  s_axis_tuser,
  output logic                       cmd_valid_o,
  output cmd_t                       cmd_o,
  input  wire q_ctl_t                ctl_i
);

  cmd_t       cmd_in;
  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_in.ch     = s_axis_tdata[7:0];
    cmd_in.rd_row = s_axis_tdata[11:8];
    cmd_in.rd_col = s_axis_tdata[18:12];
    cmd_in.rd_ok  = (32'(cmd_in.rd_row) < ROWS) && (32'(cmd_in.rd_col) <= COLS);
    if (s_axis_tuser) begin
      cmd_in.kind = KIND_READ;
    end else if (cmd_in.ch == CH_NEWLINE) begin
      cmd_in.kind = KIND_NEWLINE;
    end else if (cmd_in.ch == CH_RETURN) begin
      cmd_in.kind = KIND_RETURN;
    end else begin
      cmd_in.kind = KIND_PRINT;
    end
  end

  assign s_axis_tready = (cnt_q != 2'd2) && !ctl_i.hold;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = ctl_i.pop && (cnt_q != 2'd0);
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign cmd_o         = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcb_back.sv @@
// Back end: cell store, cursor, put/read/scroll sequencer and result register.
`default_nettype none
`include "assert_macros.svh"

module tcb_back import tcb_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cmd_valid_i,
  input  wire cmd_t                   cmd_i,
  output q_ctl_t                      ctl_o,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [7:0] cell_value, [11:8] pos_row, [17:12] pos_col, [18] scrolled,
  // [23:19] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int LINE   = COLS + 1;
  localparam int STORE  = ROWS * LINE;
  localparam int NCOPY  = (ROWS - 1) * LINE;
  localparam int BOTTOM = (ROWS - 1) * LINE;
  localparam int AW     = $clog2(STORE);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_NUL    = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_TAIL   = 3'd5;

  logic [7:0]    mem [STORE];
  logic [7:0]    rdata_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] wa_q, wa_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;

  logic          out_vld_q, out_vld_d;
  logic [7:0]    out_val_q;
  logic [3:0]    out_row_q;
  logic [5:0]    out_col_q;
  logic          out_scr_q;

  logic          out_free;
  logic          pop;
  logic          load;
  logic [7:0]    load_val;
  logic          load_scr;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] rd_addr;
  logic          row_last;
  logic          col_last;

  assign out_free = !out_vld_q || m_axis_tready;
  assign pop      = (state_q == S_IDLE) && cmd_valid_i && out_free;
  assign ctl_o.pop  = pop;
  assign ctl_o.hold = (state_q == S_CLEAR);

  assign cur_addr = AW'(row_q) * AW'(LINE) + AW'(col_q);
  assign rd_addr  = AW'(cmd_i.rd_row) * AW'(LINE) + AW'(cmd_i.rd_col);
  assign row_last = (row_q == RW'(ROWS - 1));
  assign col_last = (col_q == CW'(COLS - 1));

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    wa_d     = wa_q;
    row_d    = row_q;
    col_d    = col_q;
    we       = 1'b0;
    waddr    = cur_addr;
    wdata    = CH_NUL;
    raddr    = rd_addr;
    load     = 1'b0;
    load_val = CH_NUL;
    load_scr = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = idx_q;
        if (idx_q == AW'(STORE - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (pop) begin
          case (cmd_i.kind)
            KIND_READ: begin
              if (cmd_i.rd_ok) begin
                state_d = S_RD;
              end else begin
                load = 1'b1;
              end
            end
            KIND_RETURN: begin
              col_d = '0;
              load  = 1'b1;
            end
            KIND_NEWLINE: begin
              col_d = '0;
              if (row_last) begin
                idx_d   = '0;
                state_d = S_SCROLL;
              end else begin
                row_d = row_q + RW'(1);
                load  = 1'b1;
              end
            end
            KIND_PRINT: begin
              we      = 1'b1;
              waddr   = cur_addr;
              wdata   = cmd_i.ch;
              wa_d    = cur_addr + AW'(1);
              state_d = S_NUL;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        load     = 1'b1;
        load_val = rdata_q;
        state_d  = S_IDLE;
      end
      S_NUL: begin
        we    = 1'b1;
        waddr = wa_q;
        if (col_last) begin
          col_d = '0;
          if (row_last) begin
            idx_d   = '0;
            state_d = S_SCROLL;
          end else begin
            row_d   = row_q + RW'(1);
            load    = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          col_d   = col_q + CW'(1);
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCROLL: begin
        // write back the byte read on the previous cycle one row up
        if (idx_q != '0) begin
          we    = 1'b1;
          waddr = idx_q - AW'(1);
          wdata = rdata_q;
        end
        if (idx_q == AW'(NCOPY)) begin
          state_d = S_TAIL;
        end else begin
          raddr = idx_q + AW'(LINE);
          idx_d = idx_q + AW'(1);
        end
      end
      S_TAIL: begin
        we       = 1'b1;
        waddr    = AW'(BOTTOM);
        load     = 1'b1;
        load_scr = 1'b1;
        idx_d    = '0;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      row_q     <= row_d;
      col_q     <= col_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q <= wa_d;
    if (load) begin
      out_val_q <= load_val;
      out_row_q <= 4'(row_d);
      out_col_q <= 6'(col_d);
      out_scr_q <= load_scr;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 19){1'b0}}, out_scr_q, out_col_q,
                          out_row_q, out_val_q};

  `TCB_ASSERT(a_pop_slot_free, pop |-> (!out_vld_q || m_axis_tready), "pop with result slot busy")
  `TCB_ASSERT(a_clear_no_pop, (state_q == S_CLEAR) |-> (!pop && !load), "item taken during clear")
  `TCB_ASSERT(a_scroll_bottom, (state_q == S_SCROLL) |-> row_last, "scroll off the bottom row")
  `TCB_ASSERT(a_load_held, (load && out_vld_q) |-> m_axis_tready, "result overwritten")
  `TCB_ASSERT(a_col_range, (32'(col_q) < COLS), "cursor column out of range")

endmodule

`default_nettype wire

@@ rtl/text_console_buffer_unit.sv @@
// Top level of the text console buffer: front end, command queue and back end.
`default_nettype none

// One text window of ROWS rows by COLS columns plus a terminator column,
// kept in a byte memory of ROWS*(COLS+1) cells with one write port and a
// registered read port. Each input beat gives exactly one result beat.
// After reset the memory is zeroed one cell per cycle, and no beat is taken
// until that pass is done. A read of a cell inside the grid or its
// terminator column waits for the registered read; any other read, a
// carriage return or a plain newline is answered from the idle state. A
// printed byte is a character write then a terminator write on the one
// write port. A newline or a wrap on the bottom row scrolls: one cell is
// copied per cycle through the two ports. A two-entry queue lets the input
// side take beats while the back end is busy or a result waits to be taken.
module text_console_buffer_unit import tcb_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [7:0] char_code, [11:8] read_row, [18:12] read_col, [23:19] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [7:0] cell_value, [11:8] pos_row, [17:12] pos_col, [18] scrolled,
  // [23:19] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  logic   cmd_valid;
  cmd_t   cmd;
  q_ctl_t ctl;

  tcb_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .ctl_i         (ctl)
  );

  tcb_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .ctl_o         (ctl),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
